[design/stdm_pkg.sv]
// shared types and codes for the sparse-transpose dense multiply unit
package stdm_pkg;

   // request function codes, carried in req_tuser
   localparam logic [1:0] FUNC_CLEAR      = 2'd0;
   localparam logic [1:0] FUNC_LOAD_NZ    = 2'd1;
   localparam logic [1:0] FUNC_LOAD_DENSE = 2'd2;
   localparam logic [1:0] FUNC_QUERY      = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_RESULT_ROWS = 2'd0;
   localparam logic [1:0] CSR_INNER_ROWS  = 2'd1;
   localparam logic [1:0] CSR_RESULT_COLS = 2'd2;

   // fixed field widths of the stream and csr ports
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 7;
   localparam int OUT_VAL_W  = 48;

   // query sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_ENT,
      S_DNS,
      S_MUL,
      S_ACC,
      S_OUT
   } seq_state_type;

endpackage

[design/stdm_ram.sv]
// generic simple dual-port ram with one write port and a registered read port
module stdm_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/sparse_transpose_dense_multiply_unit.sv]
// top level of the sparse-transpose times dense matrix multiply unit
//
// Holds a column-compressed sparse matrix and a dense matrix and answers row
// queries of transpose(sparse) * dense. Clear, nonzero loads and dense loads
// produce no beat. A query emits k beats, tlast on the final one, k being
// result_cols limited to MAX_RESULT_COLS. The single multiply-accumulate
// sequencer passes each nonzero through entry ram read, dense ram read, 16x16
// multiply and accumulate in turn, and walks the column once per result
// column. req_tready is high only while the sequencer is idle; a finished
// beat waits in the output register while the next request is taken. Column
// valid bits sit in flip-flops cleared by reset and by a clear request, so no
// clearing pass is needed. Sums are exact and saturate to signed 48 bits.
module sparse_transpose_dense_multiply_unit
   import stdm_pkg::*;
#(
   parameter int MAX_RESULT_ROWS = 64,
   parameter int MAX_INNER_ROWS  = 64,
   parameter int MAX_RESULT_COLS = 16,
   parameter int MAX_NONZEROS    = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // major_index[5:0], minor_index[11:6], value[27:12]
   input  logic [1:0]            req_tuser,  // func[1:0]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_col[3:0], out_value[51:4]
   output logic                  rsp_tlast
);

   localparam int CW          = $clog2(MAX_NONZEROS + 1);
   localparam int EA_W        = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
   localparam int RA_W        = (MAX_RESULT_ROWS > 1) ? $clog2(MAX_RESULT_ROWS) : 1;
   localparam int DENSE_DEPTH = MAX_INNER_ROWS * MAX_RESULT_COLS;
   localparam int DA_W        = (DENSE_DEPTH > 1) ? $clog2(DENSE_DEPTH) : 1;
   localparam int KW          = $clog2(MAX_RESULT_COLS + 1);
   localparam int LW          = (MAX_RESULT_COLS > 1) ? $clog2(MAX_RESULT_COLS) : 1;
   localparam int ACC_W       = (CW + 32 > OUT_VAL_W + 1) ? CW + 32 : OUT_VAL_W + 1;
   localparam int ENT_W       = 22;

   // request fields
   logic               [1:0]  req_func;
   logic               [5:0]  req_major;
   logic               [5:0]  req_minor;
   logic signed        [15:0] req_value;
   logic                      req_fire;
   logic               [31:0] major_wide;
   logic               [31:0] minor_wide;
   logic            [RA_W-1:0] req_col_addr;

   assign req_func     = req_tuser;
   assign req_major    = req_tdata[5:0];
   assign req_minor    = req_tdata[11:6];
   assign req_value    = req_tdata[27:12];
   assign req_fire     = req_tvalid && req_tready;
   assign major_wide   = 32'(req_major);
   assign minor_wide   = 32'(req_minor);
   assign req_col_addr = major_wide[RA_W-1:0];

   // registers
   seq_state_type              state_ff, state_in;
   logic [6:0]                 result_rows_ff, result_rows_in;
   logic [6:0]                 inner_rows_ff, inner_rows_in;
   logic [4:0]                 result_cols_ff, result_cols_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [5:0]                 last_col_ff, last_col_in;
   logic [CW-1:0]              cur_start_ff, cur_start_in;
   logic [MAX_RESULT_ROWS-1:0] col_valid_ff, col_valid_in;
   logic                       qvalid_ff, qvalid_in;
   logic [KW-1:0]              k_ff, k_in;
   logic [LW-1:0]              l_ff, l_in;
   logic [CW-1:0]              lo_ff, lo_in;
   logic [CW-1:0]              hi_ff, hi_in;
   logic [CW-1:0]              e_ff, e_in;
   logic signed [31:0]         prod_ff, prod_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   // ram ports
   logic                  nz_we;
   logic                  dense_we;
   logic [2*CW-1:0]       range_wr_data;
   logic [2*CW-1:0]       range_rd_data;
   logic [ENT_W-1:0]      ent_rd_data;
   logic [15:0]           dense_rd_data;
   logic [DA_W-1:0]       dense_wr_addr;
   logic [DA_W-1:0]       dense_rd_addr;
   logic [31:0]           dense_wr_wide;
   logic [31:0]           dense_rd_wide;
   logic [5:0]            ent_row;
   logic signed [15:0]    ent_value;

   assign ent_row   = ent_rd_data[ENT_W-1:16];
   assign ent_value = ent_rd_data[15:0];

   // load and query checks
   logic        col_in_range;
   logic        nz_row_ok;
   logic        nz_room;
   logic        nz_order;
   logic        load_ok;
   logic        dense_ok;
   logic        query_ok;
   logic [31:0] k_wide;
   logic [KW-1:0] req_k;
   logic [CW-1:0] nz_start;

   always_comb begin
      col_in_range = ({1'b0, req_major} < result_rows_ff)
                     && (major_wide < 32'(MAX_RESULT_ROWS));
      nz_row_ok    = ({1'b0, req_minor} < inner_rows_ff)
                     && (minor_wide < 32'(MAX_INNER_ROWS));
      nz_room      = 32'(count_ff) < 32'(MAX_NONZEROS);
      nz_order     = (count_ff == '0) || (req_major >= last_col_ff);
      load_ok      = col_in_range && nz_row_ok && nz_room && nz_order;
      dense_ok     = ({1'b0, req_major} < inner_rows_ff)
                     && (major_wide < 32'(MAX_INNER_ROWS))
                     && (req_minor < {1'b0, result_cols_ff})
                     && (minor_wide < 32'(MAX_RESULT_COLS));
      k_wide       = (32'(result_cols_ff) < 32'(MAX_RESULT_COLS)) ?
                     32'(result_cols_ff) : 32'(MAX_RESULT_COLS);
      req_k        = k_wide[KW-1:0];
      query_ok     = col_in_range && (req_k != '0);
      nz_start     = col_valid_ff[req_col_addr] ? cur_start_ff : count_ff;
   end

   // ram addresses and write data
   assign dense_wr_wide = major_wide * 32'(MAX_RESULT_COLS) + minor_wide;
   assign dense_wr_addr = dense_wr_wide[DA_W-1:0];
   assign dense_rd_wide = 32'(ent_row) * 32'(MAX_RESULT_COLS) + 32'(l_ff);
   assign dense_rd_addr = dense_rd_wide[DA_W-1:0];
   assign range_wr_data = {nz_start, count_ff + 1'b1};

   // saturation of the accumulator to the output range
   logic [ACC_W-OUT_VAL_W:0] acc_top;
   logic                     acc_fits;
   logic [OUT_VAL_W-1:0]     sat_value;
   logic [31:0]              l_wide;
   logic                     l_is_last;
   logic                     rsp_load;

   always_comb begin
      acc_top   = acc_ff[ACC_W-1:OUT_VAL_W-1];
      acc_fits  = (&acc_top) || !(|acc_top);
      if (acc_fits) begin
         sat_value = acc_ff[OUT_VAL_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat_value = {1'b1, {(OUT_VAL_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(OUT_VAL_W-1){1'b1}}};
      end
      l_wide    = 32'(l_ff);
      l_is_last = (l_wide + 32'd1) == 32'(k_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_func == FUNC_QUERY) && query_ok) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (qvalid_ff && (range_rd_data[2*CW-1:CW] < range_rd_data[CW-1:0])) begin
               state_in = S_ENT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_ENT: state_in = S_DNS;
         S_DNS: state_in = S_MUL;
         S_MUL: state_in = S_ACC;
         S_ACC: begin
            if ((e_ff + 1'b1) < hi_ff) begin
               state_in = S_ENT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               if (l_is_last) begin
                  state_in = S_IDLE;
               end else if (lo_ff < hi_ff) begin
                  state_in = S_ENT;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_OUT:   rsp_load   = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
            rsp_load   = 1'b0;
         end
      endcase
      nz_we    = req_fire && (req_func == FUNC_LOAD_NZ) && load_ok;
      dense_we = req_fire && (req_func == FUNC_LOAD_DENSE) && dense_ok;
   end

   // datapath and bookkeeping next values
   always_comb begin
      result_rows_in = result_rows_ff;
      inner_rows_in  = inner_rows_ff;
      result_cols_in = result_cols_ff;
      count_in       = count_ff;
      last_col_in    = last_col_ff;
      cur_start_in   = cur_start_ff;
      col_valid_in   = col_valid_ff;
      qvalid_in      = qvalid_ff;
      k_in           = k_ff;
      l_in           = l_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      e_in           = e_ff;
      prod_in        = $signed(ent_value) * $signed(dense_rd_data);
      acc_in         = acc_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;

      // configuration writes
      if (csr_wen) begin
         case (csr_addr)
            CSR_RESULT_ROWS: result_rows_in = csr_wdata;
            CSR_INNER_ROWS:  inner_rows_in  = csr_wdata;
            CSR_RESULT_COLS: result_cols_in = csr_wdata[4:0];
            default:         result_rows_in = result_rows_ff;
         endcase
      end

      // sparse store bookkeeping
      if (req_fire && (req_func == FUNC_CLEAR)) begin
         count_in     = '0;
         last_col_in  = '0;
         col_valid_in = '0;
      end else if (nz_we) begin
         count_in                   = count_ff + 1'b1;
         last_col_in                = req_major;
         cur_start_in               = nz_start;
         col_valid_in[req_col_addr] = 1'b1;
      end

      // query capture
      if (req_fire && (req_func == FUNC_QUERY)) begin
         qvalid_in = col_valid_ff[req_col_addr];
         k_in      = req_k;
      end

      case (state_ff)
         S_START: begin
            lo_in  = qvalid_ff ? range_rd_data[2*CW-1:CW] : '0;
            hi_in  = qvalid_ff ? range_rd_data[CW-1:0] : '0;
            e_in   = qvalid_ff ? range_rd_data[2*CW-1:CW] : '0;
            l_in   = '0;
            acc_in = '0;
         end
         S_ACC: begin
            acc_in = acc_ff + {{(ACC_W-32){prod_ff[31]}}, prod_ff};
            e_in   = e_ff + 1'b1;
         end
         S_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, sat_value, l_wide[3:0]};
               rsp_last_in  = l_is_last;
               l_in         = l_ff + 1'b1;
               e_in         = lo_ff;
               acc_in       = '0;
            end
         end
         default: acc_in = acc_ff;
      endcase
   end

   // register update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         result_rows_ff <= 7'd64;
         inner_rows_ff  <= 7'd64;
         result_cols_ff <= 5'd16;
         count_ff       <= '0;
         last_col_ff    <= '0;
         col_valid_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         result_rows_ff <= result_rows_in;
         inner_rows_ff  <= inner_rows_in;
         result_cols_ff <= result_cols_in;
         count_ff       <= count_in;
         last_col_ff    <= last_col_in;
         col_valid_ff   <= col_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cur_start_ff <= cur_start_in;
      qvalid_ff    <= qvalid_in;
      k_ff         <= k_in;
      l_ff         <= l_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      e_ff         <= e_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // per-column entry range {start, end}
   stdm_ram #(
      .WIDTH (2 * CW),
      .DEPTH (MAX_RESULT_ROWS)
   ) u_range_ram (
      .clock   (clock),
      .wr_en   (nz_we),
      .wr_addr (req_col_addr),
      .wr_data (range_wr_data),
      .rd_addr (req_col_addr),
      .rd_data (range_rd_data)
   );

   // nonzero store {row, value}
   stdm_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_NONZEROS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (nz_we),
      .wr_addr (count_ff[EA_W-1:0]),
      .wr_data ({req_minor, req_value}),
      .rd_addr (e_ff[EA_W-1:0]),
      .rd_data (ent_rd_data)
   );

   // dense matrix store, row major
   stdm_ram #(
      .WIDTH (16),
      .DEPTH (DENSE_DEPTH)
   ) u_dense_ram (
      .clock   (clock),
      .wr_en   (dense_we),
      .wr_addr (dense_wr_addr),
      .wr_data (req_value),
      .rd_addr (dense_rd_addr),
      .rd_data (dense_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // an accepted nonzero grows the store by exactly one entry
   a_nz_count: assert property (@(posedge clock) disable iff (reset)
      nz_we |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("nonzero load did not advance the entry count");

   // the walk never reads past the end of the queried column
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENT) |-> (e_ff < hi_ff))
      else $error("entry walk outside column range");

   // a clear empties the sparse store
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_func == FUNC_CLEAR)) |=> ((count_ff == '0) && (col_valid_ff == '0)))
      else $error("clear left sparse entries behind");
`endif

endmodule
